// File: rtl/esd_pkg.sv
// Shared constants and helpers for the epoch seconds to UTC date converter.
// Holds field widths, reciprocal multipliers and the month start table.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

  // Field widths of the request and the result.
  localparam int EPOCH_W   = 40;
  localparam int YEAR_W    = 16;
  localparam int MONTH_W   = 4;
  localparam int MDAY_W    = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int WDAY_W    = 3;
  localparam int YDAY_W    = 9;

  // Internal widths.
  localparam int DAYNUM_W  = 24;  // biased day number, always positive
  localparam int TOD_W     = 17;  // seconds within the day
  localparam int DOE_W     = 18;  // day within the 400-year era
  localparam int ERA_W     = 7;   // biased era index
  localparam int YOE_W     = 9;   // year within the era
  localparam int DOY_W     = 9;   // March-based day of year
  localparam int MP_W      = 4;   // March-based month

  // Bias that makes the seconds count positive: a whole number of days.
  localparam logic [EPOCH_W:0]    SPLIT_BIAS = 41'd549763200000;
  // Seconds per day is 128 * 675; the odd factor is divided by reciprocal.
  localparam logic [23:0]         DAY_RECIP  = 24'd12725829;
  localparam logic [11:0]         DAY_ODD    = 12'd675;
  // Day number offset from the biased split to the era-biased day count.
  localparam logic [DAYNUM_W-1:0] ZZ_BIAS    = 24'd200348;

  // Era split.
  localparam logic [13:0]         ERA_RECIP     = 14'd14699;
  localparam logic [DOE_W-1:0]    DAYS_PER_ERA  = 18'd146097;
  localparam logic [DOE_W-1:0]    DOE_LAST      = 18'd146096;
  localparam logic [DOE_W-1:0]    DAYS_PER_CENT = 18'd36524;

  // Weekday: the biased day number plus this offset, modulo seven.
  localparam logic [DAYNUM_W-1:0] WDAY_BIAS  = 24'd3;
  localparam logic [24:0]         WDAY_RECIP = 25'd19173962;

  // Exact reciprocals for small dividends.
  localparam logic [18:0]         DIV1460_RECIP = 19'd367720;  // shift 29
  localparam logic [18:0]         DIV365_RECIP  = 19'd367720;  // shift 27
  localparam logic [12:0]         MP_RECIP      = 13'd3427;    // div 153, shift 19
  localparam logic [17:0]         HOUR_RECIP    = 18'd149131;  // div 3600, shift 29
  localparam logic [12:0]         MIN_RECIP     = 13'd4370;    // div 60, shift 18

  localparam logic [TOD_W-1:0]    SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0]         SECS_PER_MIN  = 12'd60;

  // Year 1900 plus the forty-era bias of the day number, in years.
  localparam logic [16:0]         YEAR_BASE = 17'd17900;
  // March-based day of January 1, and day of year of March 1 in a common year.
  localparam logic [DOY_W-1:0]    JAN1_DOY  = 9'd306;
  localparam logic [DOY_W-1:0]    MAR1_YDAY = 9'd59;
  localparam logic [MP_W-1:0]     MP_JAN    = 4'd10;

  // First March-based day of each month, that is (153 * mp + 2) / 5.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] start_day;
    case (mp)
      4'd0:    start_day = 9'd0;
      4'd1:    start_day = 9'd31;
      4'd2:    start_day = 9'd61;
      4'd3:    start_day = 9'd92;
      4'd4:    start_day = 9'd122;
      4'd5:    start_day = 9'd153;
      4'd6:    start_day = 9'd184;
      4'd7:    start_day = 9'd214;
      4'd8:    start_day = 9'd245;
      4'd9:    start_day = 9'd275;
      4'd10:   start_day = 9'd306;
      4'd11:   start_day = 9'd337;
      default: start_day = 9'd0;
    endcase
    return start_day;
  endfunction

endpackage

`default_nettype wire

// File: rtl/esd_day_split.sv
// Splits a signed seconds count into a biased day number and seconds of day.
// Four register stages: bias add, reciprocal multiply, remainder, correction.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_day_split
  import esd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [EPOCH_W-1:0]  seconds,
  output logic                     out_valid,
  output logic [DAYNUM_W-1:0]      day_num,
  output logic [TOD_W-1:0]         day_secs
);

  logic [3:0]           valid;
  logic [EPOCH_W:0]     u1;
  logic [24:0]          q2;
  logic [11:0]          vlo2;
  logic [6:0]           low2;
  logic [23:0]          q3;
  logic [11:0]          r3;
  logic [6:0]           low3;
  logic [48:0]          prod;
  logic [23:0]          qmul;
  logic [1:0]           delta;
  logic [11:0]          sub;
  logic [11:0]          rfix;

  // Valid bits travel with the data; nothing ever stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], in_valid};
    end
  end
  assign out_valid = valid[3];

  // Stage 1: add a whole number of days so the count is positive.
  always_ff @(posedge clk) begin
    u1 <= {seconds[EPOCH_W-1], seconds} + SPLIT_BIAS;
  end

  // Stage 2: estimate (u / 128) / 675 from the top bits of u.
  assign prod = 49'(u1[40:16]) * 49'(DAY_RECIP);

  always_ff @(posedge clk) begin
    q2   <= prod[48:24];
    vlo2 <= u1[18:7];
    low2 <= u1[6:0];
  end

  // Stage 3: remainder of the estimate; only its low bits are needed.
  assign qmul = q2[11:0] * DAY_ODD;

  always_ff @(posedge clk) begin
    q3   <= q2[23:0];
    r3   <= vlo2 - qmul[11:0];
    low3 <= low2;
  end

  // Stage 4: the estimate is at most a little low, so fix it by compares.
  always_comb begin
    if (r3 >= 12'(3 * DAY_ODD)) begin
      delta = 2'd3;
      sub   = 12'(3 * DAY_ODD);
    end else if (r3 >= 12'(2 * DAY_ODD)) begin
      delta = 2'd2;
      sub   = 12'(2 * DAY_ODD);
    end else if (r3 >= DAY_ODD) begin
      delta = 2'd1;
      sub   = DAY_ODD;
    end else begin
      delta = 2'd0;
      sub   = 12'd0;
    end
    rfix = r3 - sub;
  end

  always_ff @(posedge clk) begin
    day_num  <= q3 + ZZ_BIAS + 24'(delta);
    day_secs <= {rfix[9:0], low3};
  end

  // The reciprocal estimate is never more than one short.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid[2] |-> r3 < 12'(2 * DAY_ODD))
    else $error("day split remainder out of range");

endmodule

`default_nettype wire

// File: rtl/esd_time_of_day.sv
// Breaks seconds of the day into hour, minute and second.
// Four register stages built on exact reciprocal multiplies; no control state.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_time_of_day
  import esd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [TOD_W-1:0]  day_secs,
  output logic [HOUR_W-1:0]      hour,
  output logic [MIN_W-1:0]       minute,
  output logic [SEC_W-1:0]       second
);

  logic [34:0]        ph;
  logic [TOD_W-1:0]   secs1;
  logic [HOUR_W-1:0]  hour1;
  logic [TOD_W-1:0]   h3600;
  logic [TOD_W-1:0]   rem2;
  logic [11:0]        rs2;
  logic [HOUR_W-1:0]  hour2;
  logic [24:0]        pm;
  logic [11:0]        rs3;
  logic [MIN_W-1:0]   min3;
  logic [HOUR_W-1:0]  hour3;
  logic [11:0]        m60;

  // Stage 1: hour by reciprocal of 3600.
  assign ph = 35'(day_secs) * 35'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    hour1 <= ph[33:29];
    secs1 <= day_secs;
  end

  // Stage 2: seconds within the hour.
  assign h3600 = 17'(hour1) * SECS_PER_HOUR;
  assign rem2  = secs1 - h3600;

  always_ff @(posedge clk) begin
    rs2   <= rem2[11:0];
    hour2 <= hour1;
  end

  // Stage 3: minute by reciprocal of 60.
  assign pm = 25'(rs2) * 25'(MIN_RECIP);

  always_ff @(posedge clk) begin
    min3  <= pm[23:18];
    rs3   <= rs2;
    hour3 <= hour2;
  end

  // Stage 4: second within the minute.
  assign m60 = 12'(min3) * SECS_PER_MIN;

  always_ff @(posedge clk) begin
    hour   <= hour3;
    minute <= min3;
    second <= 6'(rs3 - m60);
  end

endmodule

`default_nettype wire

// File: rtl/esd_civil_date.sv
// Converts a biased day number into year, month, day, weekday and day of year.
// Nine register stages: era split, year of era, month, then final assembly.
// Depends on esd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module esd_civil_date
  import esd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [DAYNUM_W-1:0]  day_num,
  output logic                      out_valid,
  output logic signed [YEAR_W-1:0]  year_offset,
  output logic [MONTH_W-1:0]        month_index,
  output logic [MDAY_W-1:0]         day_of_month,
  output logic [WDAY_W-1:0]         weekday,
  output logic [YDAY_W-1:0]         day_of_year
);

  logic [8:0]            valid;

  logic [37:0]           pe;
  logic [DAYNUM_W-1:0]   wx;
  logic [48:0]           pw;
  logic [DAYNUM_W-1:0]   zz1;
  logic [DAYNUM_W-1:0]   wx1;
  logic [ERA_W-1:0]      era1;
  logic [20:0]           wq1;

  logic [DAYNUM_W-1:0]   em2;
  logic [DAYNUM_W-1:0]   er2;
  logic [2:0]            w7;
  logic [18:0]           r2;
  logic [ERA_W-1:0]      era2;
  logic [WDAY_W-1:0]     wday2;

  logic                  wrap3;
  logic [DOE_W-1:0]      doe3;
  logic [ERA_W-1:0]      era3;
  logic [WDAY_W-1:0]     wday3;

  logic [36:0]           pa;
  logic [6:0]            a4;
  logic [2:0]            b4;
  logic                  c4;
  logic [DOE_W-1:0]      doe4;
  logic [ERA_W-1:0]      era4;
  logic [WDAY_W-1:0]     wday4;

  logic [DOE_W-1:0]      n5;
  logic [DOE_W-1:0]      doe5;
  logic [15:0]           era400_5;
  logic [WDAY_W-1:0]     wday5;

  logic [36:0]           py;
  logic [YOE_W-1:0]      yoe6;
  logic [DOE_W-1:0]      doe6;
  logic [15:0]           era400_6;
  logic [WDAY_W-1:0]     wday6;

  logic [1:0]            cent7;
  logic [DOE_W-1:0]      ydays;
  logic [DOE_W-1:0]      doyw;
  logic                  leap_c;
  logic [DOY_W-1:0]      doy7;
  logic [YOE_W-1:0]      yoe7;
  logic                  leap7;
  logic [15:0]           era400_7;
  logic [WDAY_W-1:0]     wday7;

  logic [10:0]           mx;
  logic [22:0]           pmp;
  logic [MP_W-1:0]       mp8;
  logic [DOY_W-1:0]      doy8;
  logic [YOE_W-1:0]      yoe8;
  logic                  leap8;
  logic [15:0]           era400_8;
  logic [WDAY_W-1:0]     wday8;

  logic                  jan;
  logic [16:0]           ysum;
  logic [16:0]           ybias;
  logic [DOY_W-1:0]      mday9;

  // Valid bits travel with the data; nothing ever stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[7:0], in_valid};
    end
  end
  assign out_valid = valid[8];

  // Stage 1: era estimate and day number divided by seven.
  assign pe = 38'(day_num) * 38'(ERA_RECIP);
  assign wx = day_num + WDAY_BIAS;
  assign pw = 49'(wx) * 49'(WDAY_RECIP);

  always_ff @(posedge clk) begin
    zz1  <= day_num;
    wx1  <= wx;
    era1 <= pe[37:31];
    wq1  <= pw[47:27];
  end

  // Stage 2: remainder against the era estimate, and the weekday.
  assign em2 = 24'(era1) * 24'(DAYS_PER_ERA);
  assign er2 = zz1 - em2;
  assign w7  = 3'(wq1[2:0] * 3'd7);

  always_ff @(posedge clk) begin
    r2    <= er2[18:0];
    era2  <= era1;
    wday2 <= wx1[2:0] - w7;
  end

  // Stage 3: the era estimate is at most one short.
  assign wrap3 = r2 >= 19'(DAYS_PER_ERA);

  always_ff @(posedge clk) begin
    if (wrap3) begin
      doe3 <= 18'(r2 - 19'(DAYS_PER_ERA));
      era3 <= era2 + 7'd1;
    end else begin
      doe3 <= r2[DOE_W-1:0];
      era3 <= era2;
    end
    wday3 <= wday2;
  end

  // Stage 4: the leap-day corrections of the year-of-era formula.
  assign pa = 37'(doe3) * 37'(DIV1460_RECIP);

  always_ff @(posedge clk) begin
    a4    <= pa[35:29];
    b4    <= 3'(doe3 >= DAYS_PER_CENT) + 3'(doe3 >= 18'(2 * DAYS_PER_CENT))
           + 3'(doe3 >= 18'(3 * DAYS_PER_CENT)) + 3'(doe3 >= DOE_LAST);
    c4    <= doe3 == DOE_LAST;
    doe4  <= doe3;
    era4  <= era3;
    wday4 <= wday3;
  end

  // Stage 5: corrected day count and the era in years.
  always_ff @(posedge clk) begin
    n5       <= doe4 - 18'(a4) + 18'(b4) - 18'(c4);
    doe5     <= doe4;
    era400_5 <= 16'(era4) * 16'd400;
    wday5    <= wday4;
  end

  // Stage 6: year of era by reciprocal of 365.
  assign py = 37'(n5) * 37'(DIV365_RECIP);

  always_ff @(posedge clk) begin
    yoe6     <= py[35:27];
    doe6     <= doe5;
    era400_6 <= era400_5;
    wday6    <= wday5;
  end

  // Stage 7: March-based day of year and the leap flag of the year.
  always_comb begin
    cent7  = 2'(yoe6 >= 9'd100) + 2'(yoe6 >= 9'd200) + 2'(yoe6 >= 9'd300);
    ydays  = 18'(yoe6) * 18'd365 + 18'(yoe6[YOE_W-1:2]) - 18'(cent7);
    doyw   = doe6 - ydays;
    leap_c = (yoe6[1:0] == 2'd0)
             && !((yoe6 == 9'd100) || (yoe6 == 9'd200) || (yoe6 == 9'd300));
  end

  always_ff @(posedge clk) begin
    doy7     <= doyw[DOY_W-1:0];
    yoe7     <= yoe6;
    leap7    <= leap_c;
    era400_7 <= era400_6;
    wday7    <= wday6;
  end

  // Stage 8: March-based month by reciprocal of 153.
  assign mx  = 11'(doy7) * 11'd5 + 11'd2;
  assign pmp = 23'(mx) * 23'(MP_RECIP);

  always_ff @(posedge clk) begin
    mp8      <= pmp[22:19];
    doy8     <= doy7;
    yoe8     <= yoe7;
    leap8    <= leap7;
    era400_8 <= era400_7;
    wday8    <= wday7;
  end

  // Stage 9: January and February belong to the next calendar year.
  assign jan   = mp8 >= MP_JAN;
  assign ysum  = 17'(era400_8) + 17'(yoe8) + 17'(jan);
  assign ybias = ysum - YEAR_BASE;
  assign mday9 = doy8 - month_start(mp8) + 9'd1;

  always_ff @(posedge clk) begin
    year_offset  <= ybias[YEAR_W-1:0];
    day_of_month <= mday9[MDAY_W-1:0];
    weekday      <= wday8;
    if (jan) begin
      month_index <= mp8 - MP_JAN;
      day_of_year <= doy8 - JAN1_DOY;
    end else begin
      month_index <= mp8 + 4'd2;
      day_of_year <= doy8 + MAR1_YDAY + 9'(leap8);
    end
  end

  // The era estimate never falls more than one era short.
  a_era_bound: assert property (@(posedge clk) disable iff (rst)
    valid[1] |-> r2 < 19'(2 * DAYS_PER_ERA))
    else $error("era remainder out of range");

endmodule

`default_nettype wire

// File: rtl/epoch_seconds_to_utc_date_core.sv
// Top level of the epoch seconds to UTC calendar converter.
// Instantiates esd_day_split, esd_time_of_day and esd_civil_date; uses esd_pkg.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries one signed 40-bit count of seconds since 1970-01-01 00:00 UTC.
//   Every request gives exactly one result: year minus 1900, month 0..11,
//   day of month, hour, minute, second, weekday (0 is Sunday) and day of year.
//   The result is on the ports for one cycle with done high; the receiver
//   cannot hold it off, and none is needed since nothing inside ever waits.
//   The result passes through the register stages of both submodules (4 stages
//   split seconds into days, 9 stages turn the day number into a date; the time
//   of day is computed alongside and delayed to match).
//   Throughput: one request per cycle, start may stay high continuously.
//   busy is high only during reset. Reset drops every request in flight;
//   no result comes out for them.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_utc_date_core
  import esd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [EPOCH_W-1:0]   epoch_seconds,
  output logic                      done,
  output logic signed [YEAR_W-1:0]  year_offset,
  output logic [MONTH_W-1:0]        month_index,
  output logic [MDAY_W-1:0]         day_of_month,
  output logic [HOUR_W-1:0]         hour_of_day,
  output logic [MIN_W-1:0]          minute_of_hour,
  output logic [SEC_W-1:0]          second_of_minute,
  output logic [WDAY_W-1:0]         weekday,
  output logic [YDAY_W-1:0]         day_of_year
);

  localparam int TOD_DLY = 5;
  localparam int HMS_W   = HOUR_W + MIN_W + SEC_W;

  logic                  accept;
  logic                  split_valid;
  logic [DAYNUM_W-1:0]   day_num;
  logic [TOD_W-1:0]      day_secs;
  logic [HOUR_W-1:0]     tod_hour;
  logic [MIN_W-1:0]      tod_min;
  logic [SEC_W-1:0]      tod_sec;
  logic [HMS_W-1:0]      hms_dly [TOD_DLY];

  assign busy   = rst;
  assign accept = start && !busy;

  // Seconds count to day number and seconds of day.
  esd_day_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .seconds   (epoch_seconds),
    .out_valid (split_valid),
    .day_num   (day_num),
    .day_secs  (day_secs)
  );

  // Time of day runs beside the date pipeline.
  esd_time_of_day u_tod (
    .clk      (clk),
    .day_secs (day_secs),
    .hour     (tod_hour),
    .minute   (tod_min),
    .second   (tod_sec)
  );

  // Day number to calendar date; its valid output is the result strobe.
  esd_civil_date u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (split_valid),
    .day_num      (day_num),
    .out_valid    (done),
    .year_offset  (year_offset),
    .month_index  (month_index),
    .day_of_month (day_of_month),
    .weekday      (weekday),
    .day_of_year  (day_of_year)
  );

  // Delay line that lines the time of day up with the date.
  always_ff @(posedge clk) begin
    hms_dly[0] <= {tod_hour, tod_min, tod_sec};
    for (int i = 1; i < TOD_DLY; i++) begin
      hms_dly[i] <= hms_dly[i-1];
    end
  end

  assign {hour_of_day, minute_of_hour, second_of_minute} = hms_dly[TOD_DLY-1];

  // Every accepted request produces a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##13 done)
    else $error("result strobe missing after request");

  // Date fields of a result lie within their calendar ranges.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_index <= 4'd11) && (day_of_month != 5'd0)
             && (weekday <= 3'd6) && (day_of_year <= 9'd365))
    else $error("date field out of range");

  // Time fields of a result lie within their ranges.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59)
             && (second_of_minute <= 6'd59))
    else $error("time field out of range");

endmodule

`default_nettype wire
